/* rtl/tscdd_pkg.sv */
// Shared types, constants and helpers for the two-sided CUSUM drift detector.
package tscdd_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int SUM_W     = 31;
    localparam int QUO_W     = 31;
    localparam int NUM_W     = DATA_W + FRAC_BITS;
    localparam int HI_W      = NUM_W - QUO_W;
    localparam int CNT_W     = $clog2(QUO_W + 1);
    localparam int ACC_W     = DATA_W + 2;
    localparam int CFG_IDX_W = 8;

    localparam logic [SUM_W-1:0]  SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [SUM_W-1:0]  SCALE_ONE = SUM_W'(1) << FRAC_BITS;
    localparam logic [SUM_W-1:0]  K_RESET   = SUM_W'(32768);
    localparam logic [SUM_W-1:0]  H_RESET   = SUM_W'(327680);
    localparam logic [DATA_W-1:0] X_POS_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] Q_SAT     = {1'b1, {(DATA_W-1){1'b0}}};

    localparam logic                 KIND_SAMPLE     = 1'b0;
    localparam logic                 KIND_CLEAR      = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_REFERENCE_K = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_H = CFG_IDX_W'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_UP,
        S_DN,
        S_ALM,
        S_OUT
    } t_state;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num_mag;
        logic [SUM_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] q_mag;
    } t_div_rsp;

    // floor at zero, saturate at the top
    function automatic logic [SUM_W-1:0] clamp_sum(input logic signed [ACC_W-1:0] v);
        logic [SUM_W-1:0] r;
        if (v[ACC_W-1]) begin
            r = '0;
        end else if (v > $signed({{(ACC_W-SUM_W){1'b0}}, SUM_MAX})) begin
            r = SUM_MAX;
        end else begin
            r = v[SUM_W-1:0];
        end
        return r;
    endfunction

endpackage

/* rtl/tscdd_div.sv */
// Iterative restoring divider: one quotient bit per cycle, saturating magnitude.
module tscdd_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tscdd_pkg::t_div_req i_req,
    output tscdd_pkg::t_div_rsp o_rsp
);
    import tscdd_pkg::*;

    logic [SUM_W-1:0] r_rem;
    logic [QUO_W-1:0] r_lo;
    logic [QUO_W-1:0] r_q;
    logic [SUM_W-1:0] r_den;
    logic             r_sat;
    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;

    logic [SUM_W:0]   trial;
    logic [SUM_W:0]   diff;
    logic             ge;
    logic [HI_W-1:0]  num_hi;

    assign num_hi = i_req.num_mag[NUM_W-1:QUO_W];
    assign trial  = {r_rem, r_lo[QUO_W-1]};
    assign diff   = trial - {1'b0, r_den};
    assign ge     = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(QUO_W);
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end else begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= {{(SUM_W-HI_W){1'b0}}, num_hi};
            r_lo  <= i_req.num_mag[QUO_W-1:0];
            r_q   <= '0;
            r_den <= i_req.den;
            // quotient of 2^31 or more saturates either sign
            r_sat <= ({{(SUM_W-HI_W){1'b0}}, num_hi} >= i_req.den);
        end else if (r_busy && r_cnt != '0) begin
            r_rem <= ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
            r_lo  <= {r_lo[QUO_W-2:0], 1'b0};
            r_q   <= {r_q[QUO_W-2:0], ge};
        end
    end

    assign o_rsp.done  = r_busy && (r_cnt == '0);
    assign o_rsp.q_mag = r_sat ? Q_SAT : {1'b0, r_q};

endmodule

/* rtl/two_sided_cusum_drift_detector_unit.sv */
// Top level of the two-sided tabular CUSUM drift detector.
// Input channel (i_valid/o_ready) takes one word: i_kind, i_residual, i_scale.
// i_kind = 1 clears both sums and both alarms; the result word is all zero.
// i_kind = 0 standardizes the residual by the scale (1.0 when scale <= 0),
// then updates the upper and lower sums and their sticky alarms.
// Output channel (o_valid/i_ready) returns one word per input word: drift,
// both alarms and both sums after the update.
// Config channel (i_cfg_valid/o_cfg_ready, always ready) writes reference_k
// (index 0) or threshold_h (index 1); other indexes are dropped. Write only
// while idle.
// A sample word passes through a load, 31 divider steps, a result capture and
// the upper sum, lower sum and alarm states before it shows on the output. A
// clear word shows on the output in the cycle after it is accepted.
// One word is in flight at a time; o_ready is high only when idle, so the next
// word is taken only after the current result has been handed off.
// A stalled output holds its word until i_ready; no input is taken meanwhile.
// Synchronous reset returns to idle, zeroes the sums and alarms and loads
// reference_k = 0.5 and threshold_h = 5.0.
module two_sided_cusum_drift_detector_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic                               i_kind,
    input  logic signed [tscdd_pkg::DATA_W-1:0] i_residual,
    input  logic signed [tscdd_pkg::DATA_W-1:0] i_scale,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic                               o_drift,
    output logic                               o_alarm_up,
    output logic                               o_alarm_down,
    output logic [tscdd_pkg::SUM_W-1:0]         o_sum_up,
    output logic [tscdd_pkg::SUM_W-1:0]         o_sum_down,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tscdd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tscdd_pkg::DATA_W-1:0]        i_cfg_data
);
    import tscdd_pkg::*;

    t_state r_state;
    t_state n_state;

    logic [SUM_W-1:0]  r_k;
    logic [SUM_W-1:0]  r_h;
    logic [SUM_W-1:0]  r_sum_up;
    logic [SUM_W-1:0]  r_sum_dn;
    logic              r_alarm_up;
    logic              r_alarm_dn;
    logic [DATA_W-1:0] r_x;
    logic              r_neg;

    logic              in_acc;
    logic [DATA_W-1:0] res_mag;
    logic [DATA_W-1:0] n_x;
    logic signed [ACC_W-1:0] up_raw;
    logic signed [ACC_W-1:0] dn_raw;
    t_div_req          div_req;
    t_div_rsp          div_rsp;

    tscdd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign in_acc  = i_valid && o_ready;
    assign res_mag = i_residual[DATA_W-1] ? (~i_residual + 1'b1) : i_residual;

    always_comb begin
        div_req.start   = in_acc && (i_kind == KIND_SAMPLE);
        div_req.num_mag = {res_mag, {FRAC_BITS{1'b0}}};
        div_req.den     = (i_scale[DATA_W-1] || i_scale == '0) ? SCALE_ONE
                                                                : i_scale[SUM_W-1:0];
    end

    // restore sign; positive magnitude of 2^31 clips to max
    always_comb begin
        if (r_neg) begin
            n_x = ~div_rsp.q_mag + 1'b1;
        end else if (div_rsp.q_mag[DATA_W-1]) begin
            n_x = X_POS_MAX;
        end else begin
            n_x = div_rsp.q_mag;
        end
    end

    assign up_raw = $signed({{(ACC_W-SUM_W){1'b0}}, r_sum_up})
                  + $signed({{(ACC_W-DATA_W){r_x[DATA_W-1]}}, r_x})
                  - $signed({{(ACC_W-SUM_W){1'b0}}, r_k});
    assign dn_raw = $signed({{(ACC_W-SUM_W){1'b0}}, r_sum_dn})
                  - $signed({{(ACC_W-DATA_W){r_x[DATA_W-1]}}, r_x})
                  - $signed({{(ACC_W-SUM_W){1'b0}}, r_k});

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = (i_kind == KIND_CLEAR) ? S_OUT : S_DIV;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_state = S_UP;
                end
            end
            S_UP:  n_state = S_DN;
            S_DN:  n_state = S_ALM;
            S_ALM: n_state = S_OUT;
            S_OUT: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready      = (r_state == S_IDLE);
        o_valid      = (r_state == S_OUT);
        o_cfg_ready  = 1'b1;
        o_drift      = r_alarm_up || r_alarm_dn;
        o_alarm_up   = r_alarm_up;
        o_alarm_down = r_alarm_dn;
        o_sum_up     = r_sum_up;
        o_sum_down   = r_sum_dn;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= K_RESET;
            r_h <= H_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_REFERENCE_K: r_k <= i_cfg_data[SUM_W-1:0];
                CFG_THRESHOLD_H: r_h <= i_cfg_data[SUM_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_up   <= '0;
            r_sum_dn   <= '0;
            r_alarm_up <= 1'b0;
            r_alarm_dn <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc && i_kind == KIND_CLEAR) begin
                        r_sum_up   <= '0;
                        r_sum_dn   <= '0;
                        r_alarm_up <= 1'b0;
                        r_alarm_dn <= 1'b0;
                    end
                end
                S_UP: r_sum_up <= clamp_sum(up_raw);
                S_DN: r_sum_dn <= clamp_sum(dn_raw);
                S_ALM: begin
                    if (r_sum_up > r_h) begin
                        r_alarm_up <= 1'b1;
                    end
                    if (r_sum_dn > r_h) begin
                        r_alarm_dn <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_neg <= i_residual[DATA_W-1];
        end
        if (r_state == S_DIV && div_rsp.done) begin
            r_x <= n_x;
        end
    end

endmodule

/* rtl/tscdd_chk.sv */
// Port-level checker for the CUSUM drift detector, bound to the top level.
module tscdd_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       o_ready,
    input logic                       i_kind,
    input logic                       o_valid,
    input logic                       i_ready,
    input logic                       o_drift,
    input logic                       o_alarm_up,
    input logic                       o_alarm_down,
    input logic [tscdd_pkg::SUM_W-1:0] o_sum_up,
    input logic [tscdd_pkg::SUM_W-1:0] o_sum_down
);
    import tscdd_pkg::*;

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid && o_ready)
        else $error("not idle after reset");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input taken while a word is in flight");

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("ready while a result is pending");

    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_kind == KIND_CLEAR) |=>
        (o_valid && !o_drift && !o_alarm_up && !o_alarm_down &&
         o_sum_up == '0 && o_sum_down == '0))
        else $error("clear word did not zero the state");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=>
        (o_valid && $stable(o_sum_up) && $stable(o_sum_down) && $stable(o_drift) &&
         $stable(o_alarm_up) && $stable(o_alarm_down)))
        else $error("stalled result word changed");

endmodule

bind two_sided_cusum_drift_detector_unit tscdd_chk u_tscdd_chk (.*);
